FILE: hw/rtl/thpd_pkg.sv
// Shared widths, register indexes and reset values of the two-hit pair detector.
package thpd_pkg;

   localparam int HALF_W     = 16;
   localparam int HIT_W      = 2 * HALF_W;
   localparam int QUERY_W    = 8;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_QUERIES_DEF = 256;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_A     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DISTANCE = CSR_ADDR_W'(1);

   localparam logic [HALF_W-1:0] WINDOW_A_RESET     = HALF_W'(40);
   localparam logic [HALF_W-1:0] MIN_DISTANCE_RESET = HALF_W'(3);

   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [HIT_W-1:0]   hit_type;
   typedef logic [QUERY_W-1:0] query_type;

endpackage

FILE: hw/rtl/thpd_req_if.sv
// Hit request channel: valid/ready handshake with one word hit as payload.
interface thpd_req_if;
   import thpd_pkg::*;

   logic      valid;
   logic      ready;
   logic      new_subject;
   half_type  diagonal;
   half_type  query_offset;
   query_type query_index;

   modport source (output valid, new_subject, diagonal, query_offset, query_index,
                   input ready);
   modport sink   (input valid, new_subject, diagonal, query_offset, query_index,
                   output ready);
endinterface

FILE: hw/rtl/thpd_rsp_if.sv
// Pair result channel: valid/ready handshake with one triggered hit pair as payload.
interface thpd_rsp_if;
   import thpd_pkg::*;

   logic      valid;
   logic      ready;
   query_type pair_query;
   hit_type   earlier_hit;
   hit_type   later_hit;

   modport source (output valid, pair_query, earlier_hit, later_hit, input ready);
   modport sink   (input valid, pair_query, earlier_hit, later_hit, output ready);
endinterface

FILE: hw/rtl/thpd_csr_if.sv
// Register write channel: valid/ready handshake with register index and write data.
interface thpd_csr_if;
   import thpd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/two_hit_pair_detector.sv
// Two-hit pair detector: pairs each word hit with the last stored hit of its query.
//
// Usage:
//   req_chan carries word hits sorted by diagonal. A transfer on req_chan with
//   new_subject set first forgets every stored hit, then handles the hit.
//   rsp_chan carries at most one triggered pair (query, earlier hit, later hit)
//   per hit; most hits produce no transfer on rsp_chan at all.
//   csr_chan writes window_a (index 0) and min_distance (index 1); it is always
//   ready, and other indexes are accepted and ignored. Write it only while the
//   block is idle.
// Timing:
//   One hit is accepted every cycle while the evaluation stage is not held. A hit
//   is evaluated there; its pair, if any, goes to rsp_chan via the result register.
//   The per-query table is a single memory with a registered read port, read
//   when a hit is accepted and written when it is evaluated; a hit of the same
//   query directly behind takes the new value from a bypass register.
// Reset and stall:
//   Reset clears the valid bits of all queries at once (no clearing pass), the
//   pipeline valids and the registers to window_a = 40, min_distance = 3.
//   When the receiver holds rsp_ready low with a pair waiting, the evaluation
//   stage holds its hit and req_ready drops in the same cycle.
module two_hit_pair_detector #(
   parameter int NUM_QUERIES = thpd_pkg::NUM_QUERIES_DEF
) (
   input logic        clock,
   input logic        reset,
   thpd_req_if.sink   req_chan,
   thpd_rsp_if.source rsp_chan,
   thpd_csr_if.sink   csr_chan
);
   import thpd_pkg::*;

   // Only query numbers that fit in the 8-bit index field can ever be stored.
   localparam int MAX_QUERY   = 1 << QUERY_W;
   localparam int TABLE_DEPTH = (NUM_QUERIES < MAX_QUERY) ? NUM_QUERIES : MAX_QUERY;
   localparam int QIDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [QUERY_W:0] QUERY_LIMIT = (QUERY_W + 1)'(TABLE_DEPTH);

   // Configuration registers.
   half_type window_a_ff;
   half_type min_distance_ff;

   // Per-query last hit memory and its valid bits.
   hit_type                 hit_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  hit_valid_ff;
   logic [TABLE_DEPTH-1:0]  hit_valid_in;
   hit_type                 rd_data_ff;

   // Evaluation stage.
   logic      s1_valid_ff;
   logic      s1_valid_in;
   logic      s1_new_subject_ff;
   hit_type   s1_hit_ff;
   query_type s1_query_ff;

   // Bypass for a table write that lands on the same edge as the read.
   logic              byp_valid_ff;
   logic [QIDX_W-1:0] byp_addr_ff;
   hit_type           byp_data_ff;

   // Result register.
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   query_type rsp_query_ff;
   hit_type   rsp_earlier_ff;
   hit_type   rsp_later_ff;

   logic              req_xfer;
   logic              s1_fire;
   logic [QIDX_W-1:0] s1_idx;
   logic [QIDX_W-1:0] req_idx;
   logic              s1_in_range;
   logic              last_valid;
   hit_type           last_hit;
   logic [HIT_W:0]    hit_diff;
   logic              dist_neg;
   logic              ge_window;
   logic              ge_min;
   logic              wr_en;
   logic              emit;

   // -------------------------------------------------------------------------
   // Configuration port. Writes are always taken.
   // -------------------------------------------------------------------------
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_a_ff     <= WINDOW_A_RESET;
         min_distance_ff <= MIN_DISTANCE_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_WINDOW_A:     window_a_ff     <= csr_chan.data;
            CSR_MIN_DISTANCE: min_distance_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Handshakes. The evaluation stage moves on whenever the result register
   // is free or being drained, so a new hit can enter behind it every cycle.
   // -------------------------------------------------------------------------
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign req_idx     = req_chan.query_index[QIDX_W-1:0];
   assign s1_idx      = s1_query_ff[QIDX_W-1:0];
   assign s1_in_range = {1'b0, s1_query_ff} < QUERY_LIMIT;

   // -------------------------------------------------------------------------
   // Evaluation. The new-subject flag hides every stored hit, including the
   // one of this query. The distance is a 33-bit signed difference, so a hit
   // that goes backwards is negative and is dropped.
   // -------------------------------------------------------------------------
   assign last_valid = hit_valid_ff[s1_idx] && !s1_new_subject_ff;
   assign last_hit   = (byp_valid_ff && (byp_addr_ff == s1_idx)) ? byp_data_ff : rd_data_ff;
   assign hit_diff   = {1'b0, s1_hit_ff} - {1'b0, last_hit};
   assign dist_neg   = hit_diff[HIT_W];
   assign ge_window  = !dist_neg && (hit_diff[HIT_W-1:0] >= {{HALF_W{1'b0}}, window_a_ff});
   assign ge_min     = !dist_neg && (hit_diff[HIT_W-1:0] >= {{HALF_W{1'b0}}, min_distance_ff});

   always_comb begin
      wr_en = 1'b0;
      emit  = 1'b0;
      if (s1_fire && s1_in_range) begin
         if (!last_valid || ge_window) begin
            wr_en = 1'b1;
         end else if (ge_min) begin
            wr_en = 1'b1;
            emit  = 1'b1;
         end
      end
   end

   always_comb begin
      hit_valid_in = hit_valid_ff;
      if (s1_fire && s1_new_subject_ff) begin
         hit_valid_in = '0;
      end
      if (wr_en) begin
         hit_valid_in[s1_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_valid_ff <= '0;
      end else begin
         hit_valid_ff <= hit_valid_in;
      end
   end

   // Table memory: one write and one registered read per cycle. The read
   // returns the old entry when both hit the same address on one edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hit_mem[s1_idx] <= s1_hit_ff;
      end
      if (req_xfer) begin
         rd_data_ff <= hit_mem[req_idx];
      end
   end

   // The bypass captures the write made on the edge a hit enters, the only
   // write its memory read can have missed.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         byp_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         byp_addr_ff <= s1_idx;
         byp_data_ff <= s1_hit_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Evaluation stage register.
   // -------------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_new_subject_ff <= req_chan.new_subject;
         s1_hit_ff         <= {req_chan.diagonal, req_chan.query_offset};
         s1_query_ff       <= req_chan.query_index;
      end
   end

   // -------------------------------------------------------------------------
   // Result register.
   // -------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_query_ff   <= s1_query_ff;
         rsp_earlier_ff <= last_hit;
         rsp_later_ff   <= s1_hit_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pair_query  = rsp_query_ff;
   assign rsp_chan.earlier_hit = rsp_earlier_ff;
   assign rsp_chan.later_hit   = rsp_later_ff;

`ifndef SYNTH
   // A new subject leaves at most the current query marked as holding a hit.
   a_subject_clear : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_new_subject_ff) |=> ($countones(hit_valid_ff) <= 1))
      else $error("valid bits survived a new subject");

   // A pair appears only right after the evaluation stage moved a hit on.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("result appeared without an evaluated hit");

   // An emitted pair never goes backwards in hit order.
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      emit |-> (s1_hit_ff >= last_hit))
      else $error("emitted pair is out of order");

   // Every stored hit leaves its query marked valid.
   a_store_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> hit_valid_ff[$past(s1_idx)])
      else $error("stored hit not marked valid");
`endif

endmodule

FILE: bench/two_hit_pair_checker.sv
// Checker that predicts the triggered hit pairs and compares them with the block's results.
`timescale 1ns / 1ps

module two_hit_pair_checker #(
   parameter int NUM_QUERIES = thpd_pkg::NUM_QUERIES_DEF
) (
   input  logic clock,
   input  logic reset,
   thpd_req_if  req_mon,
   thpd_rsp_if  rsp_mon,
   thpd_csr_if  csr_mon,
   output int   mismatch_count,
   output int   pairs_outstanding
);
   import thpd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      query_type pair_query;
      hit_type   earlier_hit;
      hit_type   later_hit;
   } hit_pair_type;

   hit_pair_type pairs_due[$];
   hit_type      stored_hit   [NUM_QUERIES];
   bit           stored_valid [NUM_QUERIES];
   half_type     window_a;
   half_type     min_distance;
   int           failures = 0;

   always @(posedge clock) begin
      hit_type      current;
      longint       distance;
      int           q;
      hit_pair_type seen;
      hit_pair_type due;
      if (reset) begin
         foreach (stored_valid[i]) stored_valid[i] = 1'b0;
         window_a     = WINDOW_A_RESET;
         min_distance = MIN_DISTANCE_RESET;
         pairs_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_WINDOW_A:     window_a = csr_mon.data;
               CSR_MIN_DISTANCE: min_distance = csr_mon.data;
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.pair_query, rsp_mon.earlier_hit, rsp_mon.later_hit};
            if (pairs_due.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("unexpected pair: query=%0d earlier=%h later=%h",
                           seen.pair_query, seen.earlier_hit, seen.later_hit);
            end else begin
               due = pairs_due.pop_front();
               if (seen.pair_query !== due.pair_query || seen.earlier_hit !== due.earlier_hit ||
                   seen.later_hit !== due.later_hit) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("pair mismatch: expected query=%0d earlier=%h later=%h, got %s",
                              due.pair_query, due.earlier_hit, due.later_hit,
                              $sformatf("query=%0d earlier=%h later=%h", seen.pair_query,
                                        seen.earlier_hit, seen.later_hit));
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            // The subject flag forgets every stored hit before this hit is looked at.
            if (req_mon.new_subject)
               foreach (stored_valid[i]) stored_valid[i] = 1'b0;
            q = int'(req_mon.query_index);
            if (q < NUM_QUERIES) begin
               current = {req_mon.diagonal, req_mon.query_offset};
               if (!stored_valid[q]) begin
                  stored_hit[q]   = current;
                  stored_valid[q] = 1'b1;
               end else begin
                  distance = longint'(current) - longint'(stored_hit[q]);
                  if (distance >= longint'(window_a)) begin
                     stored_hit[q] = current;
                  end else if (distance >= longint'(min_distance)) begin
                     pairs_due.push_back('{query_type'(q), stored_hit[q], current});
                     stored_hit[q] = current;
                  end
               end
            end
         end
      end
      mismatch_count    <= failures;
      pairs_outstanding <= pairs_due.size();
   end

endmodule

FILE: bench/two_hit_pair_detector_tb.sv
// Top of the two-hit pair detector bench: clock, reset, stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps

module two_hit_pair_detector_tb;
   import thpd_pkg::*;

   // Phase plan: the first phase runs on the reset values, the others rewrite both
   // registers, including the zero window and the largest and smallest settings.
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 240;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int DRAIN_CYCLES     = 8;

   // An index that the block does not decode; a transfer to it must change nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_INDEX = CSR_ADDR_W'(7);

   logic clock;
   logic reset;

   thpd_req_if req_if ();
   thpd_rsp_if rsp_if ();
   thpd_csr_if csr_if ();

   int mismatch_count;
   int pairs_outstanding;

   // Long receiver hold-offs asked for by the stimulus; the receiver serves them in order.
   int hold_offs_asked = 0;

   // Sender pacing: a burst of transfers, then a gap of random length.
   int burst_left = 0;

   // Settings that the stimulus aims its hit distances at.
   longint cur_window = longint'(WINDOW_A_RESET);
   longint cur_min    = longint'(MIN_DISTANCE_RESET);

   // Last hit sent for each query, used as the base of the next one of that query.
   bit [HIT_W-1:0] recent_hit [NUM_QUERIES_DEF];

   half_type window_plan [PHASES] = '{WINDOW_A_RESET, 16'hffff, 16'd0, 16'd1,
                                      16'd1000, 16'd200, 16'hffff, 16'd12};
   half_type min_plan    [PHASES] = '{MIN_DISTANCE_RESET, 16'd0, 16'd3, 16'd0,
                                      16'hffff, 16'd17, 16'hffff, 16'd11};

   two_hit_pair_detector dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   two_hit_pair_checker pair_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .csr_mon           (csr_if),
      .mismatch_count    (mismatch_count),
      .pairs_outstanding (pairs_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs and a handshake never completes.
   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offers one hit and waits for its transfer. Before the first hit of a burst the
   // sender may drop valid for a random gap, so gaps land on every pipeline phase.
   task automatic offer_hit(input logic new_subject, input half_type diagonal,
                            input half_type query_offset, input query_type query_index);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid        <= 1'b1;
      req_if.new_subject  <= new_subject;
      req_if.diagonal     <= diagonal;
      req_if.query_offset <= query_offset;
      req_if.query_index  <= query_index;
      do @(posedge clock); while (!req_if.ready);
      recent_hit[query_index] = {diagonal, query_offset};
   endtask

   // Stops offering hits and waits until every predicted pair has been transferred.
   // Hits that cause no pair may still be in the pipeline then, so a short pause
   // follows to let them drain.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pairs_outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes one register. Valid is left high so that back-to-back writes stay legal;
   // the caller lowers it after the last one.
   task automatic write_register(input logic [CSR_ADDR_W-1:0] index, input half_type value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic set_phase(input half_type window, input half_type min_dist,
                            input bit with_spare);
      settle();
      write_register(CSR_WINDOW_A, window);
      write_register(CSR_MIN_DISTANCE, min_dist);
      if (with_spare)
         write_register(CSR_SPARE_INDEX, half_type'($urandom()));
      csr_if.valid <= 1'b0;
      cur_window = longint'(window);
      cur_min    = longint'(min_dist);
   endtask

   // A value between lo and hi, or lo when the range is empty.
   function automatic longint span(input longint lo, input longint hi);
      if (hi <= lo)
         return lo;
      return lo + longint'($urandom_range(int'(hi - lo), 0));
   endfunction

   // Builds the next hit of a query relative to its last one. The largest share of distances
   // falls inside the pairing range; the rest probe the overlap zone, the exact window
   // edge, restarts, unsorted (negative) steps and wild jumps.
   function automatic hit_type next_hit(input query_type q);
      longint delta;
      case ($urandom_range(0, 11))
         0:             delta = -longint'($urandom_range(1, 300));
         1, 2:          delta = span(0, cur_min - 1);
         3, 4, 5, 6, 7: delta = span(cur_min, cur_window - 1);
         8:             delta = cur_window;
         9:             delta = cur_window - 1;
         10:            delta = span(cur_window, cur_window + 70000);
         default:       delta = longint'($urandom());
      endcase
      return hit_type'(longint'(recent_hit[q]) + delta);
   endfunction

   // Receiver pacing. Normally it runs stretches of always-ready, mostly-ready,
   // mostly-stalled and alternating patterns. When the stimulus asks for a hold-off,
   // it keeps ready low for a long hold-off while hits keep arriving, so the
   // block fills up and has to stall its input.
   initial begin : receiver
      int served;
      int stretch;
      int mode;
      served = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_offs_asked != served) begin
            served++;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
               case (mode)
                  0:       rsp_if.ready <= 1'b1;
                  1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_if.ready <= !rsp_if.ready;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int        p;
      int        sent;
      int        run_len;
      int        pool_size;
      query_type pool [8];
      query_type qsel;
      hit_type   h;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.new_subject  <= 1'b0;
      req_if.diagonal     <= '0;
      req_if.query_offset <= '0;
      req_if.query_index  <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed hits on the reset settings (window 40, overlap 3).
      offer_hit(1'b1, 16'd0, 16'd0, 8'd0);         // First hit of a query is stored.
      offer_hit(1'b0, 16'd0, 16'd3, 8'd0);         // Distance equal to the overlap pairs.
      offer_hit(1'b0, 16'd0, 16'd5, 8'd0);         // Overlapping hit is dropped.
      offer_hit(1'b0, 16'd0, 16'd42, 8'd0);        // One below the window still pairs.
      offer_hit(1'b0, 16'd0, 16'd82, 8'd0);        // Exactly the window restarts.
      offer_hit(1'b0, 16'd0, 16'd81, 8'd0);        // A step backwards is dropped.
      offer_hit(1'b0, 16'hffff, 16'hffff, 8'd255); // The all-ones hit is an ordinary hit.
      offer_hit(1'b0, 16'hffff, 16'hffff, 8'd255); // Zero distance is below the overlap.
      offer_hit(1'b0, 16'hffff, 16'hfffa, 8'd254);
      offer_hit(1'b0, 16'hffff, 16'hffff, 8'd254); // Pair whose later hit is all ones.
      offer_hit(1'b0, 16'd0, 16'hfffe, 8'd1);
      offer_hit(1'b0, 16'd1, 16'd2, 8'd1);         // Pair across a diagonal boundary.
      offer_hit(1'b1, 16'd2, 16'd0, 8'd0);         // New subject forgets query 0.
      offer_hit(1'b0, 16'd2, 16'd10, 8'd1);        // Query 1 was forgotten as well.
      offer_hit(1'b0, 16'd2, 16'd13, 8'd1);

      for (p = 0; p < PHASES; p++) begin
         if (p != 0)
            set_phase(window_plan[p], min_plan[p], p == 1);

         // Early phases start with a long receiver hold-off while hits keep flowing.
         if (p < 2)
            hold_offs_asked++;

         // With a zero window every non-negative distance restarts.
         if (cur_window == 0) begin
            offer_hit(1'b1, 16'd9, 16'd100, 8'd3);
            offer_hit(1'b0, 16'd9, 16'd105, 8'd3);
            offer_hit(1'b0, 16'd9, 16'd104, 8'd3);
         end

         // Random part: subjects of sorted-looking hits over a small pool of queries,
         // so that the same query comes back often, with some noise mixed in.
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            pool_size = $urandom_range(1, 8);
            foreach (pool[i]) pool[i] = query_type'($urandom());
            run_len = $urandom_range(4, 40);
            for (int k = 0; k < run_len; k++) begin
               if ($urandom_range(0, 9) == 0) begin
                  h = hit_type'($urandom());
                  offer_hit(($urandom_range(0, 7) == 0), h[HIT_W-1:HALF_W], h[HALF_W-1:0],
                            query_type'($urandom()));
               end else begin
                  pool_size = (pool_size < 1) ? 1 : pool_size;
                  qsel = pool[$urandom_range(0, pool_size - 1)];
                  h = next_hit(qsel);
                  offer_hit(k == 0, h[HIT_W-1:HALF_W], h[HALF_W-1:0], qsel);
               end
               sent++;
            end
         end
      end

      settle();
      if (mismatch_count == 0 && pairs_outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/thpd_pkg.sv
hw/rtl/thpd_req_if.sv
hw/rtl/thpd_rsp_if.sv
hw/rtl/thpd_csr_if.sv
hw/rtl/two_hit_pair_detector.sv
bench/two_hit_pair_checker.sv
bench/two_hit_pair_detector_tb.sv
